@@ src/bts_pkg.sv @@
// Shared constants and types for the bilinear texture sampler.
package bts_pkg;

  // Fixed field formats
  localparam int CHANNEL_BITS    = 12;
  localparam int COORD_FRAC_BITS = 16;
  localparam int SIZE_BITS       = 9;
  localparam int POS_BITS        = 8;
  localparam int CHANNELS        = 3;

  // Derived datapath widths
  localparam int SCALED_BITS = COORD_FRAC_BITS + SIZE_BITS;
  localparam int WEIGHT_BITS = COORD_FRAC_BITS + 1;
  localparam int ROW_BITS    = CHANNEL_BITS + COORD_FRAC_BITS;
  localparam int PROD_BITS   = ROW_BITS + WEIGHT_BITS;
  localparam int SUM_BITS    = ROW_BITS + COORD_FRAC_BITS + 1;

  // Configuration register indexes
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  // Item kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Channel slots inside one texel
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [CHANNEL_BITS-1:0]             chan_t;
  typedef logic [CHANNELS-1:0][CHANNEL_BITS-1:0] texel_t;
  typedef logic [WEIGHT_BITS-1:0]              weight_t;
  typedef logic [ROW_BITS-1:0]                 row_t;
  typedef logic [PROD_BITS-1:0]                prod_t;
  typedef logic [SUM_BITS-1:0]                 sum_t;

endpackage

@@ src/bilinear_texture_sampler.sv @@
// Bilinear texture sampler with repeat addressing: texel store and blend pipeline.
//
// Usage: one command transaction is taken at a rising edge where start is high and
// busy is low; busy stays low, so a transaction may be issued every cycle.
// action selects the kind: a texel write stores red/green/blue at (texel_x,
// texel_y) and gives no result; writes outside the texture in use are dropped.
// A sample blends the four texels around (coord_u * width, coord_v * height),
// wrapping to column or row 0 at the edge, and gives out_red/out_green/out_blue.
// The result is on the outputs for exactly one cycle with done high; it is
// registered by the final sum and rounding stage, and one result leaves per
// cycle at full rate. The pipeline has five register stages: coordinate scale,
// store read, row blend, column products, final sum and rounding. The store is
// held twice, each copy with two read ports, so all four corners are read in
// the same cycle whatever the width; a write lands in both copies. Texture size
// registers are written over cfg_write/cfg_index/cfg_data; the user must do so
// only while no sample is in flight; the block does not enforce this. Reset
// clears the pipeline valid bits and sets both sizes to 256; the store is not
// cleared, and texels must be written before sampling. The receiver cannot
// stall; results are never held.
module bilinear_texture_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [bts_pkg::SIZE_BITS-1:0]       cfg_data,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic [bts_pkg::POS_BITS-1:0]        texel_x,
  input  logic [bts_pkg::POS_BITS-1:0]        texel_y,
  input  logic [bts_pkg::CHANNEL_BITS-1:0]    red,
  input  logic [bts_pkg::CHANNEL_BITS-1:0]    green,
  input  logic [bts_pkg::CHANNEL_BITS-1:0]    blue,
  input  logic [bts_pkg::COORD_FRAC_BITS-1:0] coord_u,
  input  logic [bts_pkg::COORD_FRAC_BITS-1:0] coord_v,
  // result channel
  output logic                                done,
  output logic [bts_pkg::CHANNEL_BITS-1:0]    out_red,
  output logic [bts_pkg::CHANNEL_BITS-1:0]    out_green,
  output logic [bts_pkg::CHANNEL_BITS-1:0]    out_blue
);

  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int AW         = XW + YW;
  localparam int DEPTH      = 1 << AW;
  localparam int SB         = bts_pkg::SIZE_BITS;
  localparam int FB         = bts_pkg::COORD_FRAC_BITS;
  localparam int CB         = bts_pkg::CHANNEL_BITS;
  localparam int NCH        = bts_pkg::CHANNELS;
  localparam int SIZE_LIMIT = (1 << SB) - 1;
  localparam int MAXW_CLIP  = (MAX_WIDTH < SIZE_LIMIT) ? MAX_WIDTH : SIZE_LIMIT;
  localparam int MAXH_CLIP  = (MAX_HEIGHT < SIZE_LIMIT) ? MAX_HEIGHT : SIZE_LIMIT;
  localparam logic [SB-1:0] MAXW_SIZE = SB'(MAXW_CLIP);
  localparam logic [SB-1:0] MAXH_SIZE = SB'(MAXH_CLIP);
  localparam bts_pkg::weight_t WEIGHT_ONE = bts_pkg::WEIGHT_BITS'(1 << FB);
  localparam bts_pkg::sum_t    ROUND_HALF = bts_pkg::SUM_BITS'(1) << (2 * FB - 1);

  // configuration registers and effective sizes
  logic [SB-1:0] tex_width;
  logic [SB-1:0] tex_height;
  logic [SB-1:0] eff_w;
  logic [SB-1:0] eff_h;

  // command decode
  logic            cmd_take;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  bts_pkg::texel_t wr_texel;

  // stage 1: scaled coordinates
  logic                            s1_valid;
  logic [bts_pkg::SCALED_BITS-1:0] s1_su;
  logic [bts_pkg::SCALED_BITS-1:0] s1_sv;
  logic [bts_pkg::SCALED_BITS-1:0] su_next;
  logic [bts_pkg::SCALED_BITS-1:0] sv_next;

  // corner selection
  logic [SB-1:0] x1_raw;
  logic [SB-1:0] y1_raw;
  logic [SB-1:0] x1;
  logic [SB-1:0] y1;
  logic [SB-1:0] x2;
  logic [SB-1:0] y2;
  logic [AW-1:0] addr11;
  logic [AW-1:0] addr12;
  logic [AW-1:0] addr21;
  logic [AW-1:0] addr22;

  // stage 2: corner texels and weights
  logic            s2_valid;
  logic [FB-1:0]   s2_fu;
  logic [FB-1:0]   s2_fv;
  bts_pkg::texel_t rd11;
  bts_pkg::texel_t rd12;
  bts_pkg::texel_t rd21;
  bts_pkg::texel_t rd22;

  // texel store, two copies
  bts_pkg::texel_t store_a [DEPTH];
  bts_pkg::texel_t store_b [DEPTH];

  // stage 3: horizontal row blends
  logic                         s3_valid;
  logic [FB-1:0]                s3_fv;
  bts_pkg::row_t [NCH-1:0]      s3_row1;
  bts_pkg::row_t [NCH-1:0]      s3_row2;
  bts_pkg::row_t [NCH-1:0]      row1_next;
  bts_pkg::row_t [NCH-1:0]      row2_next;
  bts_pkg::weight_t             wu_lo;
  bts_pkg::weight_t             wu_hi;

  // stage 4: vertical products
  logic                         s4_valid;
  bts_pkg::prod_t [NCH-1:0]     s4_p1;
  bts_pkg::prod_t [NCH-1:0]     s4_p2;
  bts_pkg::prod_t [NCH-1:0]     p1_next;
  bts_pkg::prod_t [NCH-1:0]     p2_next;
  bts_pkg::weight_t             wv_lo;
  bts_pkg::weight_t             wv_hi;

  // stage 5: rounded result
  bts_pkg::texel_t              res_next;
  bts_pkg::sum_t [NCH-1:0]      sum_round;

  assign busy = 1'b0;

  // Hold the size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= SB'(256);
      tex_height <= SB'(256);
    end else if (cfg_write) begin
      case (cfg_index)
        bts_pkg::REG_TEX_WIDTH:  tex_width  <= cfg_data;
        bts_pkg::REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, beyond the store acts as its maximum
  always_comb begin
    if (tex_width == '0) begin
      eff_w = SB'(1);
    end else if (tex_width > MAXW_SIZE) begin
      eff_w = MAXW_SIZE;
    end else begin
      eff_w = tex_width;
    end
    if (tex_height == '0) begin
      eff_h = SB'(1);
    end else if (tex_height > MAXH_SIZE) begin
      eff_h = MAXH_SIZE;
    end else begin
      eff_h = tex_height;
    end
  end

  // Decode the command transaction; drop writes outside the texture
  always_comb begin
    cmd_take = start && !busy;
    wr_en    = cmd_take && (action == bts_pkg::ACT_WRITE)
               && ({1'b0, texel_x} < eff_w) && ({1'b0, texel_y} < eff_h);
    wr_addr  = {YW'(texel_y), XW'(texel_x)};
    wr_texel[bts_pkg::CH_RED]   = red;
    wr_texel[bts_pkg::CH_GREEN] = green;
    wr_texel[bts_pkg::CH_BLUE]  = blue;
    su_next  = {{SB{1'b0}}, coord_u} * {{FB{1'b0}}, eff_w};
    sv_next  = {{SB{1'b0}}, coord_v} * {{FB{1'b0}}, eff_h};
  end

  // Stage 1: scale the coordinates by the texture size
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_take && (action == bts_pkg::ACT_SAMPLE);
    end
    s1_su <= su_next;
    s1_sv <= sv_next;
  end

  // Pick corner texels, wrapping the second corner to zero at the edge
  always_comb begin
    x1_raw = s1_su[bts_pkg::SCALED_BITS-1:FB];
    y1_raw = s1_sv[bts_pkg::SCALED_BITS-1:FB];
    x1     = (x1_raw >= eff_w) ? eff_w - SB'(1) : x1_raw;
    y1     = (y1_raw >= eff_h) ? eff_h - SB'(1) : y1_raw;
    x2     = (x1 + SB'(1) == eff_w) ? '0 : x1 + SB'(1);
    y2     = (y1 + SB'(1) == eff_h) ? '0 : y1 + SB'(1);
    addr11 = {YW'(y1), XW'(x1)};
    addr12 = {YW'(y2), XW'(x1)};
    addr21 = {YW'(y1), XW'(x2)};
    addr22 = {YW'(y2), XW'(x2)};
  end

  // Store copy A: left column corners
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_a[wr_addr] <= wr_texel;
    end
    rd11 <= store_a[addr11];
    rd12 <= store_a[addr12];
  end

  // Store copy B: right column corners
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_b[wr_addr] <= wr_texel;
    end
    rd21 <= store_b[addr21];
    rd22 <= store_b[addr22];
  end

  // Stage 2: carry the fractional weights alongside the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_fu <= s1_su[FB-1:0];
    s2_fv <= s1_sv[FB-1:0];
  end

  // Blend each row horizontally, exact
  always_comb begin
    wu_hi = {1'b0, s2_fu};
    wu_lo = WEIGHT_ONE - wu_hi;
    for (int c = 0; c < NCH; c++) begin
      row1_next[c] = bts_pkg::row_t'(rd11[c]) * bts_pkg::row_t'(wu_lo)
                     + bts_pkg::row_t'(rd21[c]) * bts_pkg::row_t'(wu_hi);
      row2_next[c] = bts_pkg::row_t'(rd12[c]) * bts_pkg::row_t'(wu_lo)
                     + bts_pkg::row_t'(rd22[c]) * bts_pkg::row_t'(wu_hi);
    end
  end

  // Stage 3: register row blends
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_row1 <= row1_next;
    s3_row2 <= row2_next;
    s3_fv   <= s2_fv;
  end

  // Weight rows vertically
  always_comb begin
    wv_hi = {1'b0, s3_fv};
    wv_lo = WEIGHT_ONE - wv_hi;
    for (int c = 0; c < NCH; c++) begin
      p1_next[c] = bts_pkg::prod_t'(s3_row1[c]) * bts_pkg::prod_t'(wv_lo);
      p2_next[c] = bts_pkg::prod_t'(s3_row2[c]) * bts_pkg::prod_t'(wv_hi);
    end
  end

  // Stage 4: register products
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_p1 <= p1_next;
    s4_p2 <= p2_next;
  end

  // Sum and round to nearest, halves up
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_round[c] = bts_pkg::SUM_BITS'(s4_p1[c]) + bts_pkg::SUM_BITS'(s4_p2[c])
                     + ROUND_HALF;
      res_next[c]  = sum_round[c][2*FB +: CB];
    end
  end

  // Stage 5: drive the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
    out_red   <= res_next[bts_pkg::CH_RED];
    out_green <= res_next[bts_pkg::CH_GREEN];
    out_blue  <= res_next[bts_pkg::CH_BLUE];
  end

endmodule
